@@ hdl/spjq_pkg.sv @@
// ----------------------------------------------------------------------------
// spjq_pkg
// Shared widths, codes and types of the stable priority job queue.
// ----------------------------------------------------------------------------
package spjq_pkg;

  localparam int JOB_W  = 16;
  localparam int PRIO_W = 8;
  localparam int OCC_W  = 5;
  localparam int STAT_W = 2;

  // Request mode codes
  localparam logic MODE_QUEUE = 1'b0;
  localparam logic MODE_TAKE  = 1'b1;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // Operation broadcast to every cell in the row
  typedef struct packed {
    logic                     ins;
    logic                     take;
    logic [JOB_W-1:0]         job;
    logic signed [PRIO_W-1:0] prio;
  } cell_ctrl_t;

  // Contents of one cell
  typedef struct packed {
    logic [JOB_W-1:0]         job;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

endpackage

@@ hdl/spjq_if.sv @@
// ----------------------------------------------------------------------------
// spjq_req_if / spjq_rsp_if
// Valid/ready channels carrying request and result words of the job queue.
// ----------------------------------------------------------------------------
interface spjq_req_if;
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic [spjq_pkg::JOB_W-1:0]       job_id;
  logic signed [spjq_pkg::PRIO_W-1:0] priority_req;

  modport source (output valid, mode, job_id, priority_req, input ready);
  modport sink   (input valid, mode, job_id, priority_req, output ready);
endinterface

interface spjq_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [spjq_pkg::STAT_W-1:0]        status;
  logic [spjq_pkg::JOB_W-1:0]         taken_job;
  logic signed [spjq_pkg::PRIO_W-1:0] taken_priority;
  logic [spjq_pkg::OCC_W-1:0]         occupancy;

  modport source (output valid, status, taken_job, taken_priority, occupancy, input ready);
  modport sink   (input valid, status, taken_job, taken_priority, occupancy, output ready);
endinterface

@@ hdl/spjq_cell.sv @@
// ----------------------------------------------------------------------------
// spjq_cell
// One slot of the sorted row. Holds a job, keeps it, takes the new job, or
// takes a neighbor's job so the row stays sorted and stable.
// ----------------------------------------------------------------------------
module spjq_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                 clk_i,
  input  spjq_pkg::cell_ctrl_t ctrl_i,
  input  logic [CNT_W-1:0]     count_i,
  input  logic                 prev_keep_i,
  input  spjq_pkg::entry_t     prev_entry_i,
  input  spjq_pkg::entry_t     next_entry_i,
  output logic                 keep_o,
  output spjq_pkg::entry_t     entry_o
);

  spjq_pkg::entry_t entry_q, entry_d;
  logic             occupied;

  // Keep the stored job if it is in use and ranks equal or higher
  assign occupied = CNT_W'(IDX) < count_i;
  assign keep_o   = occupied && (entry_q.prio >= ctrl_i.prio);
  assign entry_o  = entry_q;

  // Pick the next contents
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (keep_o) begin
        entry_d = entry_q;
      end else if (prev_keep_i) begin
        entry_d.job  = ctrl_i.job;
        entry_d.prio = ctrl_i.prio;
      end else begin
        entry_d = prev_entry_i;
      end
    end else if (ctrl_i.take) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

@@ hdl/stable_priority_job_queue.sv @@
// ----------------------------------------------------------------------------
// stable_priority_job_queue
// Sorted job queue built as a row of DEPTH cells; inserts behind all equal
// or higher priorities, takes from the head.
// ----------------------------------------------------------------------------
// Result: each accepted request's result word is registered and valid in the next cycle.
// Throughput: one request per cycle while results are taken; the row of cells
// updates all slots in parallel at the accepting edge.
// Reset: the job count and the result valid clear; cell contents are unset
// and only slots below the count are ever read.
module stable_priority_job_queue #(
  parameter int DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spjq_req_if.sink  req_i,
  spjq_rsp_if.source rsp_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]     count_q, count_d;
  logic                 accept;
  logic                 is_take;
  logic                 full;
  logic                 empty;
  spjq_pkg::cell_ctrl_t ctrl;
  spjq_pkg::entry_t     entries [DEPTH];
  logic                 keeps   [DEPTH];

  logic                               rsp_valid_q;
  logic [spjq_pkg::STAT_W-1:0]        status_q, status_d;
  logic [spjq_pkg::JOB_W-1:0]         taken_job_q, taken_job_d;
  logic signed [spjq_pkg::PRIO_W-1:0] taken_prio_q, taken_prio_d;
  logic [spjq_pkg::OCC_W-1:0]         occ_q;

  // Accept while the result register is free or draining
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign is_take     = req_i.mode == spjq_pkg::MODE_TAKE;
  assign full        = count_q == CNT_W'(DEPTH);
  assign empty       = count_q == '0;

  // Broadcast the operation to the row
  always_comb begin
    ctrl.ins  = accept && !is_take && !full;
    ctrl.take = accept && is_take && !empty;
    ctrl.job  = req_i.job_id;
    ctrl.prio = req_i.priority_req;
  end

  // Row of cells, each fed by its neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spjq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .count_i      (count_q),
      .prev_keep_i  ((i == 0) ? 1'b1 : keeps[(i == 0) ? 0 : i - 1]),
      .prev_entry_i (entries[(i == 0) ? 0 : i - 1]),
      .next_entry_i (entries[(i == DEPTH - 1) ? i : i + 1]),
      .keep_o       (keeps[i]),
      .entry_o      (entries[i])
    );
  end

  // Next count and result word
  always_comb begin
    count_d      = count_q;
    status_d     = spjq_pkg::STATUS_DONE;
    taken_job_d  = '0;
    taken_prio_d = '0;
    if (is_take) begin
      if (empty) begin
        status_d = spjq_pkg::STATUS_EMPTY;
      end else begin
        taken_job_d  = entries[0].job;
        taken_prio_d = entries[0].prio;
        count_d      = count_q - CNT_W'(1);
      end
    end else begin
      if (full) begin
        status_d = spjq_pkg::STATUS_FULL;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  // Advance the count and the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q     <= status_d;
      taken_job_q  <= taken_job_d;
      taken_prio_q <= taken_prio_d;
      occ_q        <= spjq_pkg::OCC_W'(count_d);
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = status_q;
  assign rsp_o.taken_job      = taken_job_q;
  assign rsp_o.taken_priority = taken_prio_q;
  assign rsp_o.occupancy      = occ_q;

endmodule
